### src/rspe_pkg.sv
`default_nettype none

package rspe_pkg;

  localparam int unsigned MAX_PARITY = 32;
  localparam int unsigned CNT_W = $clog2(MAX_PARITY + 1);
  localparam logic [CNT_W-1:0] DEFAULT_PARITY = CNT_W'(10);
  localparam logic [8:0] GF_POLY = 9'h11D;
  localparam logic [7:0] GF_ALPHA = 8'h02;

  typedef logic [MAX_PARITY:0][7:0] gen_t;
  typedef logic [MAX_PARITY-1:0][7:0] rem_t;
  typedef gen_t [MAX_PARITY:1] gen_tab_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] acc;
    x = {1'b0, a};
    y = b;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) begin
        acc = acc ^ x[7:0];
      end
      y = y >> 1;
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return acc;
  endfunction

  // g(x) = prod (x - alpha^k), k = 0 .. n-1, entry 0 is the leading coefficient
  function automatic gen_tab_t gen_table();
    gen_tab_t tab;
    gen_t g;
    logic [7:0] root;
    tab = '0;
    for (int n = 1; n <= int'(MAX_PARITY); n++) begin
      g = '0;
      g[0] = 8'h01;
      root = 8'h01;
      for (int k = 0; k < n; k++) begin
        for (int i = k + 1; i >= 1; i--) begin
          g[i] = g[i] ^ gf_mul(g[i-1], root);
        end
        root = gf_mul(root, GF_ALPHA);
      end
      tab[n] = g;
    end
    return tab;
  endfunction

  localparam gen_tab_t GEN_TABLE = gen_table();

endpackage

`default_nettype wire

### src/reed_solomon_parity_encoder.sv
// First parity byte: valid once the last beat moves from the input register to obuf_r.
// One message beat per cycle; a run emits parity_count beats, one per out_ready cycle.
// A last beat waits in the input register until the previous run's parity has drained.
// Reset (rst_n low, synchronous): parity_count = 10, generator reloaded, remainder cleared,
// no beat pending on either channel.
`default_nettype none

module reed_solomon_parity_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_parity_byte,
  output logic            out_last_parity,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_parity_count
);

  localparam int unsigned MP = rspe_pkg::MAX_PARITY;
  localparam int unsigned CW = rspe_pkg::CNT_W;

  logic [CW-1:0]    n_r;
  rspe_pkg::gen_t   gen_r;
  rspe_pkg::rem_t   rem_r;
  rspe_pkg::rem_t   rem_upd;
  rspe_pkg::rem_t   obuf_r;
  logic [CW-1:0]    ocnt_r;
  logic             stg_v_r;
  logic [7:0]       stg_data_r;
  logic             stg_last_r;
  logic             stg_take;
  logic [7:0]       fb;
  logic [CW-1:0]    cfg_n;

  always_comb begin
    if (cfg_parity_count == '0) begin
      cfg_n = CW'(1);
    end else if (7'(cfg_parity_count) > 7'(MP)) begin
      cfg_n = CW'(MP);
    end else begin
      cfg_n = CW'(cfg_parity_count);
    end
  end

  // entries at or above n stay zero since the generator is zero there
  always_comb begin
    fb = stg_data_r ^ rem_r[0];
    for (int i = 0; i < int'(MP); i++) begin
      if (i < int'(MP) - 1) begin
        rem_upd[i] = rem_r[i+1] ^ rspe_pkg::gf_mul(fb, gen_r[i+1]);
      end else begin
        rem_upd[i] = rspe_pkg::gf_mul(fb, gen_r[i+1]);
      end
    end
  end

  assign out_valid       = (ocnt_r != '0);
  assign out_parity_byte = obuf_r[0];
  assign out_last_parity = (ocnt_r == CW'(1));

  assign stg_take = stg_v_r && (!stg_last_r || (ocnt_r == '0) ||
                    ((ocnt_r == CW'(1)) && out_ready));
  assign in_ready = !stg_v_r || stg_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= rspe_pkg::DEFAULT_PARITY;
      gen_r   <= rspe_pkg::GEN_TABLE[rspe_pkg::DEFAULT_PARITY];
      rem_r   <= '0;
      ocnt_r  <= '0;
      stg_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_r   <= cfg_n;
        gen_r <= rspe_pkg::GEN_TABLE[cfg_n];
        rem_r <= '0;
      end else if (stg_take) begin
        rem_r <= stg_last_r ? '0 : rem_upd;
      end

      if (stg_take && stg_last_r) begin
        ocnt_r <= n_r;
      end else if (out_valid && out_ready) begin
        ocnt_r <= ocnt_r - CW'(1);
      end

      if (in_ready) begin
        stg_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      stg_data_r <= in_data_byte;
      stg_last_r <= in_last_byte;
    end
    if (stg_take && stg_last_r) begin
      obuf_r <= rem_upd;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < int'(MP) - 1; i++) begin
        obuf_r[i] <= obuf_r[i+1];
      end
      obuf_r[MP-1] <= '0;
    end
  end

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != '0) && (n_r <= CW'(MP)))
    else $error("parity count out of range");

  a_gen_lead: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r[0] == 8'h01)
    else $error("generator leading coefficient not one");

  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && stg_last_r && (ocnt_r > CW'(1)) |-> !in_ready)
    else $error("last beat accepted over pending parity");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    stg_take && stg_last_r |=> ocnt_r == $past(n_r))
    else $error("parity run length mismatch");

endmodule

`default_nettype wire
